/* src/qdl_pkg.sv */
`timescale 1ns / 1ps

package qdl_pkg;

    localparam int LEVEL_W = 8;
    localparam int HIST_W  = 4;
    localparam int DUTY_W  = 10;
    localparam int MODE_W  = 2;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TOGGLE = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        DRIVE_LOW  = 2'd0,
        DRIVE_PWM  = 2'd1,
        DRIVE_HIGH = 2'd2
    } drive_mode_t;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 8'd255;
    localparam logic [LEVEL_W-1:0] HIGH_THRESH = 8'd250;
    localparam logic [LEVEL_W-1:0] LOW_THRESH  = 8'd15;
    localparam logic [LEVEL_W-1:0] STEP_RESET  = 8'd5;

    localparam logic [HIST_W-1:0] HIST_EDGE_LEAD  = 4'b0011;
    localparam logic [HIST_W-1:0] HIST_EDGE_TRAIL = 4'b1001;

endpackage

/* src/quadrature_dimmer_level.sv */
`timescale 1ns / 1ps

// pipeline: an accepted input word is held in the input register and passes to the result
// register once the result register is empty or the result side takes its word
// throughput: one input word per cycle, sustained while the result side takes words
// reset: step size returns to 5, line history, level and remembered level clear to zero,
// both pipeline stages empty

module quadrature_dimmer_level
    import qdl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,       // step_size

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // line_a, line_b, zero fill
    input  logic [0:0]  s_axis_tuser,   // opcode

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // level, drive_mode, pwm_duty, changed, zero fill
);

    logic [LEVEL_W-1:0] step_reg;

    logic               in_valid_reg;
    logic               in_op_reg;
    logic               in_a_reg;
    logic               in_b_reg;

    logic               prev_a_reg;
    logic               prev_a_next;
    logic               prev_b_reg;
    logic               prev_b_next;
    logic [HIST_W-1:0]  hist_a_reg;
    logic [HIST_W-1:0]  hist_a_next;
    logic [HIST_W-1:0]  hist_b_reg;
    logic [HIST_W-1:0]  hist_b_next;
    logic [LEVEL_W-1:0] level_reg;
    logic [LEVEL_W-1:0] level_next;
    logic [LEVEL_W-1:0] remem_reg;
    logic [LEVEL_W-1:0] remem_next;

    logic               out_valid_reg;
    logic [LEVEL_W-1:0] out_level_reg;
    drive_mode_t        out_mode_reg;
    drive_mode_t        out_mode_next;
    logic [DUTY_W-1:0]  out_duty_reg;
    logic [DUTY_W-1:0]  out_duty_next;
    logic               out_changed_reg;
    logic               changed_next;

    logic               out_free;
    logic               work_fire;
    logic [LEVEL_W:0]   sum_up;
    logic [LEVEL_W-1:0] enc_level;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign work_fire     = in_valid_reg && out_free;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_changed_reg, out_duty_reg, out_mode_reg, out_level_reg};

    assign sum_up = {1'b0, level_reg} + {1'b0, step_reg};

    always_comb
    begin
        prev_a_next  = prev_a_reg;
        prev_b_next  = prev_b_reg;
        hist_a_next  = hist_a_reg;
        hist_b_next  = hist_b_reg;
        level_next   = level_reg;
        remem_next   = remem_reg;
        changed_next = 1'b0;
        enc_level    = level_reg;
        if (in_op_reg == OP_TOGGLE)
        begin
            changed_next = 1'b1;
            if (level_reg == '0)
            begin
                level_next = (remem_reg == '0) ? LEVEL_MAX : remem_reg;
                remem_next = '0;
            end
            else
            begin
                level_next = '0;
            end
        end
        else if (in_a_reg != prev_a_reg || in_b_reg != prev_b_reg)
        begin
            changed_next = 1'b1;
            prev_a_next  = in_a_reg;
            prev_b_next  = in_b_reg;
            hist_a_next  = {hist_a_reg[HIST_W-2:0], in_a_reg};
            hist_b_next  = {hist_b_reg[HIST_W-2:0], in_b_reg};
            if (hist_a_next == HIST_EDGE_LEAD && hist_b_next == HIST_EDGE_TRAIL)
            begin
                enc_level = sum_up[LEVEL_W] ? LEVEL_MAX : sum_up[LEVEL_W-1:0];
            end
            else if (hist_a_next == HIST_EDGE_TRAIL && hist_b_next == HIST_EDGE_LEAD)
            begin
                enc_level = (level_reg > step_reg) ? level_reg - step_reg : '0;
            end
            level_next = enc_level;
            if (enc_level != '0 && remem_reg != '0)
            begin
                remem_next = '0;
            end
        end
    end

    always_comb
    begin
        out_duty_next = '0;
        if (level_next >= HIGH_THRESH)
        begin
            out_mode_next = DRIVE_HIGH;
        end
        else if (level_next > LOW_THRESH)
        begin
            out_mode_next = DRIVE_PWM;
            out_duty_next = {level_next, 2'b00};
        end
        else
        begin
            out_mode_next = DRIVE_LOW;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_a_reg    <= 1'b0;
            prev_b_reg    <= 1'b0;
            hist_a_reg    <= '0;
            hist_b_reg    <= '0;
            level_reg     <= '0;
            remem_reg     <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                step_reg <= cfg_data;
            end
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (work_fire)
            begin
                prev_a_reg <= prev_a_next;
                prev_b_reg <= prev_b_next;
                hist_a_reg <= hist_a_next;
                hist_b_reg <= hist_b_next;
                level_reg  <= level_next;
                remem_reg  <= remem_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_op_reg <= s_axis_tuser[0];
            in_a_reg  <= s_axis_tdata[0];
            in_b_reg  <= s_axis_tdata[1];
        end
        if (work_fire)
        begin
            out_level_reg   <= level_next;
            out_mode_reg    <= out_mode_next;
            out_duty_reg    <= out_duty_next;
            out_changed_reg <= changed_next;
        end
    end

endmodule
